// File: sv/lpt_pkg.sv
package lpt_pkg;

  localparam int DEFAULT_DEPTH = 64;
  localparam int CNT_W = 7;
  localparam int NUM_W = 41;

  // command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_DRAW = 2'd2;

  // register indexes
  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MAX_X = 3'd2;
  localparam logic [2:0] REG_MAX_Y = 3'd3;
  localparam logic [2:0] REG_LIMIT = 3'd4;

  // one table entry as held in memory
  typedef struct packed {
    logic [31:0] birth;
    logic [31:0] life;
    logic [31:0] col_b;
    logic [31:0] col_e;
    logic [31:0] vy;
    logic [31:0] vx;
    logic [31:0] oy;
    logic [31:0] ox;
  } entry_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

// File: sv/lpt_ram.sv
module lpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lpt_blend.sv
module lpt_blend
  import lpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  div_ctl_t               ctl_in,
  output div_ctl_t               ctl_out,
  input  logic [31:0]            life,
  input  logic [3:0][NUM_W-1:0]  num,
  output logic [3:0][7:0]        quo
);

  logic [3:0][NUM_W-1:0] rem;
  logic [2:0]            step;
  logic                  busy;
  logic [NUM_W-1:0]      trial;

  assign trial = {{(NUM_W-32){1'b0}}, life} << step;
  assign ctl_out.start = 1'b0;
  assign ctl_out.busy  = busy;

  // restoring division, one quotient bit per cycle on all four channels
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (ctl_in.start) begin
      busy <= 1'b1;
      step <= 3'd7;
    end else if (busy) begin
      if (step == 3'd0) busy <= 1'b0;
      step <= step - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      rem <= num;
      quo <= '0;
    end else if (busy) begin
      for (int c = 0; c < 4; c++) begin
        if (rem[c] >= trial) begin
          rem[c]       <= rem[c] - trial;
          quo[c][step] <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/linear_particle_table.sv
// Particle table with a saturating clock.
// Input channel s_*: s_tuser carries the command (tick, add, draw), s_tdata the
// tick amount and the particle fields. Output channel m_*: one status item for
// tick, add and unknown commands; a draw gives one item per live particle (or
// one status item when none), m_tlast on the final item of the command.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready.
// Tick and add go through the status state to their result. A draw first sweeps
// the table for expired entries (a read and a check for each kept entry, plus a
// move for each removed one), then emits each entry in order: a memory read, the
// multiplies, loading the bit-serial colour divider, waiting on its 8 quotient
// bits and handing the item to the output register.
// The input is taken only when the sequencer is idle; a result that waits in
// the output register does not block acceptance, but the next result waits
// for the receiver. At reset the clock and the entry count clear, the box
// opens fully and the limit is 64; the memory itself is not cleared.
module linear_particle_table
  import lpt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tick_step, start_x, start_y, velocity_x, velocity_y, begin_color,
  // final_color, life_span, spawn_offset
  input  logic [287:0] s_tdata,
  // command
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x, pos_y, pixel_color, add_accepted, live_count, table_full, pad
  output logic [111:0] m_tdata,
  // particle_valid
  output logic         m_tuser,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_STAT = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_CHK  = 4'd3;
  localparam logic [3:0] S_MWR  = 4'd4;
  localparam logic [3:0] S_ERD  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;
  localparam logic [3:0] S_DST  = 4'd9;

  logic [3:0]       state;
  logic [31:0]      min_x, min_y, max_x, max_y;
  logic [CNT_W-1:0] limit;
  logic [31:0]      clock_now;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic             acc;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  entry_t           wdata, rdata;

  logic [CNT_W-1:0] eff_limit;
  logic             out_free;
  logic             out_load;
  logic [32:0]      age_rd;
  logic             expired;

  // per-entry working registers
  logic signed [64:0] px, py;
  logic [31:0]        ox, oy, col_b, life;
  logic [3:0]         dec;
  logic               col_en;
  logic [3:0][NUM_W-1:0] num;
  logic [3:0][7:0]    quo;
  div_ctl_t           dctl_in, dctl_out;

  // request fields
  logic [31:0] f_dt, f_sx, f_sy, f_vx, f_vy, f_cb, f_ce, f_life, f_off;
  assign {f_off, f_life, f_ce, f_cb, f_vy, f_vx, f_sy, f_sx, f_dt} = s_tdata;

  assign eff_limit = (limit > DEPTH_C) ? DEPTH_C : limit;
  assign out_free  = !m_tvalid || m_tready;
  assign out_load  = ((state == S_STAT) || (state == S_OUT)) && out_free;
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign age_rd    = {1'b0, clock_now} - {1'b0, rdata.birth};
  assign expired   = $signed({age_rd[32], age_rd}) > $signed({2'b00, rdata.life});

  lpt_ram #(.WIDTH($bits(entry_t)), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  lpt_blend u_blend (
    .clk, .rst, .ctl_in(dctl_in), .ctl_out(dctl_out), .life, .num, .quo
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= 32'h8000_0000;
      min_y <= 32'h8000_0000;
      max_x <= 32'h7FFF_FFFF;
      max_y <= 32'h7FFF_FFFF;
      limit <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_X: min_x <= cfg_data;
        REG_MIN_Y: min_y <= cfg_data;
        REG_MAX_X: max_x <= cfg_data;
        REG_MAX_Y: max_y <= cfg_data;
        REG_LIMIT: limit <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // spawn time: clock plus signed offset, saturated
  logic signed [33:0] birth_sum;
  logic [31:0]        birth_sat;
  logic [32:0]        tick_sum;
  assign birth_sum = $signed({2'b00, clock_now}) + 34'($signed(f_off));
  assign birth_sat = birth_sum[33] ? 32'd0 : (birth_sum[32] ? 32'hFFFF_FFFF : birth_sum[31:0]);
  assign tick_sum  = {1'b0, clock_now} + {1'b0, f_dt};

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    raddr = idx[AW-1:0];
    if (state == S_IDLE) begin
      we    = s_tvalid && s_tuser == CMD_ADD && count < eff_limit;
      waddr = count[AW-1:0];
      wdata = '{birth: birth_sat, life: f_life, col_b: f_cb, col_e: f_ce,
                vy: f_vy, vx: f_vx, oy: f_sy, ox: f_sx};
    end else if (state == S_CHK) begin
      raddr = AW'(count - 7'd1);
    end else if (state == S_MWR) begin
      we = 1'b1;
    end
  end

  // position: start plus floor(product / 65536), max test then min test
  function automatic logic [31:0] clampf(input logic [31:0] st, input logic signed [64:0] p,
                                         input logic [31:0] lo, input logic [31:0] hi);
    logic signed [64:0] v;
    v = 65'($signed(st)) + (p >>> 16);
    if (v > 65'($signed(hi))) return hi;
    else if (v < 65'($signed(lo))) return lo;
    else return v[31:0];
  endfunction

  logic [31:0] pos_x, pos_y, pix;
  always_comb begin
    pos_x = clampf(ox, px, min_x, max_x);
    pos_y = clampf(oy, py, min_y, max_y);
    for (int c = 0; c < 4; c++) begin
      pix[c*8 +: 8] = col_en ? (dec[c] ? col_b[c*8 +: 8] - quo[c] : col_b[c*8 +: 8] + quo[c])
                             : 8'd0;
    end
  end

  // divider loads the numerators in S_DST, the cycle after they are registered
  assign dctl_in.start = (state == S_DST);
  assign dctl_in.busy  = 1'b0;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      clock_now <= '0;
      count     <= '0;
      idx       <= '0;
      acc       <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tready && !out_load) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            acc <= (s_tuser == CMD_ADD) && (count < eff_limit);
            idx <= '0;
            case (s_tuser)
              CMD_TICK: begin
                clock_now <= tick_sum[32] ? 32'hFFFF_FFFF : tick_sum[31:0];
                state     <= S_STAT;
              end
              CMD_ADD: begin
                if (count < eff_limit) count <= count + 7'd1;
                state <= S_STAT;
              end
              CMD_DRAW: state <= S_RD;
              default:  state <= S_STAT;
            endcase
          end
        end
        S_STAT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= 1'b0;
            m_tlast  <= 1'b1;
            m_tdata  <= {7'd0, count >= eff_limit, count, acc, 96'd0};
            state    <= S_IDLE;
          end
        end
        // sweep out expired entries, refilling from the top
        S_RD: begin
          if (idx >= count) begin
            idx   <= '0;
            state <= S_ERD;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (expired) begin
            state <= S_MWR;
          end else begin
            idx   <= idx + 7'd1;
            state <= S_RD;
          end
        end
        S_MWR: begin
          count <= count - 7'd1;
          state <= S_RD;
        end
        // emit live entries
        S_ERD: begin
          if (idx >= count) state <= (count == '0) ? S_STAT : S_IDLE;
          else              state <= S_MUL;
        end
        S_MUL: begin
          px     <= $signed({age_rd[32], age_rd[31:0]}) * $signed(rdata.vx);
          py     <= $signed({age_rd[32], age_rd[31:0]}) * $signed(rdata.vy);
          ox     <= rdata.ox;
          oy     <= rdata.oy;
          col_b  <= rdata.col_b;
          life   <= rdata.life;
          col_en <= !age_rd[32] && age_rd[31:0] != 32'd0 && rdata.life != 32'd0;
          for (int c = 0; c < 4; c++) begin
            if (rdata.col_e[c*8 +: 8] >= rdata.col_b[c*8 +: 8]) begin
              dec[c] <= 1'b0;
              num[c] <= NUM_W'(age_rd[31:0])
                        * NUM_W'(rdata.col_e[c*8 +: 8] - rdata.col_b[c*8 +: 8]);
            end else begin
              dec[c] <= 1'b1;
              num[c] <= NUM_W'(age_rd[31:0])
                        * NUM_W'(rdata.col_b[c*8 +: 8] - rdata.col_e[c*8 +: 8])
                        + NUM_W'(rdata.life - 32'd1);
            end
          end
          state <= S_DST;
        end
        S_DST: state <= S_DIV;
        S_DIV: begin
          if (!dctl_out.busy) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= 1'b1;
            m_tlast  <= (idx + 7'd1 == count);
            m_tdata  <= {7'd0, count >= eff_limit, count, 1'b0, pix, pos_y, pos_x};
            idx      <= idx + 7'd1;
            state    <= S_ERD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_C)
    else $error("entry count above table depth");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> !dctl_out.busy)
    else $error("result taken while divider busy");
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != S_IDLE)
    else $error("accepted item left sequencer idle");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> idx < count)
    else $error("emit index past entry count");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import lpt_pkg::*;
();

  localparam int DEPTH = 64;
  localparam int STALL_LIMIT = 6000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // one input item
  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] dt;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] cb;
    logic [31:0] ce;
    logic [31:0] life;
    logic [31:0] ofs;
  } particle_cmd_t;

  // one output item
  typedef struct packed {
    logic        pv;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] col;
    logic        lst;
    logic        acc;
    logic [6:0]  cnt;
    logic        full;
  } draw_result_t;

  typedef struct {
    particle_cmd_t c;
    bit            typed;
    draw_result_t  r;
  } stim_row_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [287:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [111:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [31:0]  cfg_data;

  linear_particle_table #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [31:0] bx_lo, by_lo, bx_hi, by_hi;
  logic [6:0]  lim_reg;
  logic [31:0] now_t;
  logic [6:0]  n_live;
  logic [31:0] tx[DEPTH], ty[DEPTH], tvx[DEPTH], tvy[DEPTH];
  logic [31:0] tcb[DEPTH], tce[DEPTH], tlife[DEPTH], tbirth[DEPTH];

  draw_result_t pending_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_drawn = 0;
  int n_got = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int quiet = 0;
  stim_row_t rows[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned cap_limit();
    return (lim_reg > DEPTH) ? DEPTH : lim_reg;
  endfunction

  function automatic draw_result_t status_of(logic pv, logic [31:0] px, logic [31:0] py,
                                             logic [31:0] col, logic acc);
    draw_result_t r;
    r.pv = pv; r.px = px; r.py = py; r.col = col; r.lst = 1'b0; r.acc = acc;
    r.cnt = n_live;
    r.full = (n_live >= cap_limit());
    return r;
  endfunction

  // append one expected item
  function automatic void queue_result(draw_result_t r);
    pending_results = {pending_results, r};
  endfunction

  // clamped position after age clock units
  function automatic logic [31:0] clamp_pos(logic [31:0] st, logic [31:0] vel,
                                            longint age, logic [31:0] lo, logic [31:0] hi);
    longint p, q, v, mx, mn;
    p = age * longint'($signed(vel));
    q = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
    v = longint'($signed(st)) + q;
    mx = longint'($signed(hi));
    mn = longint'($signed(lo));
    if (v > mx) v = mx;
    else if (v < mn) v = mn;
    return v[31:0];
  endfunction

  // per-channel linear colour fade
  function automatic logic [31:0] fade_color(logic [31:0] s, logic [31:0] e,
                                             longint age, logic [31:0] life);
    logic [31:0] o;
    longint a, b, c, lf;
    o = '0;
    lf = longint'({32'b0, life});
    for (int sh = 24; sh >= 0; sh -= 8) begin
      a = (s >> sh) & 255;
      b = (e >> sh) & 255;
      if (b >= a) c = a + (age * (b - a)) / lf;
      else c = a - (age * (a - b) + lf - 1) / lf;
      o = o | ((c[31:0] & 32'hFF) << sh);
    end
    return o;
  endfunction

  function automatic longint age_at(int i);
    return longint'({32'b0, now_t}) - longint'({32'b0, tbirth[i]});
  endfunction

  // work out the results of one accepted item
  task automatic predict_results(particle_cmd_t c);
    draw_result_t r;
    longint t, age;
    int i, k, l;
    case (c.cmd)
      CMD_TICK: begin
        t = longint'({32'b0, now_t}) + longint'({32'b0, c.dt});
        now_t = (t > 64'sh FFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
        queue_result(status_of(0, 0, 0, 0, 0));
      end
      CMD_ADD: begin
        if (n_live < cap_limit()) begin
          k = n_live;
          t = longint'({32'b0, now_t}) + longint'($signed(c.ofs));
          if (t < 0) t = 0;
          if (t > 64'sh FFFFFFFF) t = 64'sh FFFFFFFF;
          tx[k] = c.sx; ty[k] = c.sy; tvx[k] = c.vx; tvy[k] = c.vy;
          tcb[k] = c.cb; tce[k] = c.ce; tlife[k] = c.life; tbirth[k] = t[31:0];
          n_live++;
          queue_result(status_of(0, 0, 0, 0, 1));
        end else begin
          queue_result(status_of(0, 0, 0, 0, 0));
        end
      end
      CMD_DRAW: begin
        // sweep out expired entries, the last one fills the gap
        i = 0;
        while (i < n_live) begin
          if (age_at(i) > longint'({32'b0, tlife[i]})) begin
            l = n_live - 1;
            tx[i] = tx[l]; ty[i] = ty[l]; tvx[i] = tvx[l]; tvy[i] = tvy[l];
            tcb[i] = tcb[l]; tce[i] = tce[l]; tlife[i] = tlife[l]; tbirth[i] = tbirth[l];
            n_live--;
          end else begin
            i++;
          end
        end
        for (i = 0; i < n_live; i++) begin
          age = age_at(i);
          r = status_of(1, clamp_pos(tx[i], tvx[i], age, bx_lo, bx_hi),
                        clamp_pos(ty[i], tvy[i], age, by_lo, by_hi),
                        (age > 0 && tlife[i] != 0) ? fade_color(tcb[i], tce[i], age, tlife[i])
                                                   : 32'h0, 0);
          queue_result(r);
          n_drawn++;
        end
        if (n_live == 0) queue_result(status_of(0, 0, 0, 0, 0));
      end
      default: queue_result(status_of(0, 0, 0, 0, 0));
    endcase
    pending_results[pending_results.size() - 1].lst = 1'b1;
  endtask

  // drive one item and wait for it to be taken
  task automatic send_cmd(particle_cmd_t c, bit typed, draw_result_t tr);
    if ($urandom_range(99) < tx_idle) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= c.cmd;
    s_tdata  <= {c.ofs, c.life, c.ce, c.cb, c.vy, c.vx, c.sy, c.sx, c.dt};
    do @(posedge clk); while (!s_tready);
    predict_results(c);
    if (typed) pending_results[pending_results.size() - 1] = tr;
    n_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_X: bx_lo = val;
      REG_MIN_Y: by_lo = val;
      REG_MAX_X: bx_hi = val;
      REG_MAX_Y: by_hi = val;
      REG_LIMIT: lim_reg = val[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every expected item is back, then let the block settle
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_box(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                         logic [31:0] y1, logic [6:0] lim);
    write_reg(REG_MIN_X, x0);
    write_reg(REG_MIN_Y, y0);
    write_reg(REG_MAX_X, x1);
    write_reg(REG_MAX_Y, y1);
    write_reg(REG_LIMIT, {25'b0, lim});
  endtask

  function automatic particle_cmd_t make_cmd(logic [1:0] cmd, logic [31:0] dt);
    particle_cmd_t c;
    c.cmd = cmd; c.dt = dt;
    c.sx = $urandom; c.sy = $urandom; c.vx = $urandom; c.vy = $urandom;
    c.cb = $urandom; c.ce = $urandom; c.life = $urandom; c.ofs = $urandom;
    return c;
  endfunction

  // mostly sane particle streams with a share of raw noise
  function automatic particle_cmd_t random_cmd(bit wild);
    particle_cmd_t c;
    int pick;
    pick = $urandom_range(99);
    c = make_cmd((pick < 45) ? CMD_ADD : (pick < 75) ? CMD_TICK :
                 (pick < 95) ? CMD_DRAW : CMD_UNUSED,
                 wild ? $urandom : $urandom_range(0, 32'h8000));
    if ($urandom_range(9) != 0) begin
      c.sx = $urandom_range(0, 32'h01000000) - 32'h00800000;
      c.sy = $urandom_range(0, 32'h01000000) - 32'h00800000;
      if ($urandom_range(3) != 0) begin
        c.vx = $urandom_range(0, 32'h00400000) - 32'h00200000;
        c.vy = $urandom_range(0, 32'h00400000) - 32'h00200000;
      end
      c.life = $urandom_range(0, 32'h00040000);
      c.ofs = $urandom_range(0, 32'h00020000) - 32'h00010000;
    end
    return c;
  endfunction

  function automatic stim_row_t row(particle_cmd_t c);
    stim_row_t r;
    r.c = c; r.typed = 0; r.r = '0;
    return r;
  endfunction

  function automatic stim_row_t row_typed(particle_cmd_t c, logic acc, logic [6:0] cnt,
                                          logic full);
    stim_row_t r;
    r.c = c; r.typed = 1;
    r.r = '{pv: 0, px: 0, py: 0, col: 0, lst: 1, acc: acc, cnt: cnt, full: full};
    return r;
  endfunction

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= rx_idle);
  end

  // compare each output item with the oldest expectation
  always @(posedge clk) begin
    draw_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{pv: m_tuser, px: m_tdata[31:0], py: m_tdata[63:32], col: m_tdata[95:64],
              lst: m_tlast, acc: m_tdata[96], cnt: m_tdata[103:97], full: m_tdata[104]};
      n_got++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected item %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 30)
            $display("%0t: mismatch exp pv=%b x=%h y=%h col=%h last=%b acc=%b cnt=%0d full=%b",
                     $time, want.pv, want.px, want.py, want.col, want.lst, want.acc,
                     want.cnt, want.full,
                     " got pv=%b x=%h y=%h col=%h last=%b acc=%b cnt=%0d full=%b",
                     got.pv, got.px, got.py, got.col, got.lst, got.acc, got.cnt, got.full);
        end
      end
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    particle_cmd_t c;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    m_tready = 1'b0;
    bx_lo = 32'h80000000; by_lo = 32'h80000000;
    bx_hi = 32'h7FFFFFFF; by_hi = 32'h7FFFFFFF;
    lim_reg = 7'd64; now_t = '0; n_live = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    tx_idle = 27;
    rx_idle = 52;

    // directed rows at reset settings
    rows = {rows, row_typed(make_cmd(CMD_DRAW, 0), 0, 0, 0)};
    rows = {rows, row_typed(make_cmd(CMD_TICK, 0), 0, 0, 0)};
    rows = {rows, row_typed(make_cmd(CMD_UNUSED, 32'hFFFFFFFF), 0, 0, 0)};
    c = make_cmd(CMD_ADD, 0);
    c.sx = 32'h7FFFFFFF; c.sy = 32'h80000000; c.vx = 32'h7FFFFFFF; c.vy = 32'h80000000;
    c.cb = 32'hFF00FF00; c.ce = 32'h00FF00FF; c.life = 32'h00010000; c.ofs = 0;
    rows = {rows, row_typed(c, 1, 1, 0)};
    c.sx = 32'h80000000; c.sy = 32'h7FFFFFFF; c.vx = 32'h80000000; c.vy = 32'h7FFFFFFF;
    c.cb = 32'h00000000; c.ce = 32'hFFFFFFFF; c.life = 32'hFFFFFFFF; c.ofs = 32'h7FFFFFFF;
    rows = {rows, row_typed(c, 1, 2, 0)};
    // spawn before time zero clamps, zero life
    c.ofs = 32'h80000000; c.life = 0;
    rows = {rows, row_typed(c, 1, 3, 0)};
    c.ofs = 32'hFFFF0000; c.life = 32'h00030000; c.cb = 32'h10F080FF; c.ce = 32'hF0108000;
    c.vx = 32'h00010000; c.vy = 32'hFFFE0000; c.sx = 0; c.sy = 0;
    rows = {rows, row(c)};
    rows = {rows, row(make_cmd(CMD_DRAW, 0))};
    rows = {rows, row(make_cmd(CMD_TICK, 32'h00008000))};
    // zero-life entry expires, last entry is swapped in and checked again
    rows = {rows, row(make_cmd(CMD_DRAW, 0))};
    rows = {rows, row(make_cmd(CMD_TICK, 32'h00018000))};
    rows = {rows, row(make_cmd(CMD_DRAW, 0))};
    rows = {rows, row(random_cmd(0))};
    rows = {rows, row(make_cmd(CMD_TICK, 32'h00100000))};
    rows = {rows, row(make_cmd(CMD_DRAW, 0))};
    foreach (rows[i]) send_cmd(rows[i].c, rows[i].typed, rows[i].r);
    drain();

    // tight box and a small limit
    set_box(32'hFF9C0000, 32'hFF9C0000, 32'h00640000, 32'h00640000, 7'd5);
    repeat (75) send_cmd(random_cmd(0), 0, '0);
    drain();

    // inverted box, adds all refused
    set_box(32'h00100000, 32'h00200000, 32'hFFF00000, 32'hFFE00000, 7'd0);
    repeat (20) send_cmd(random_cmd(0), 0, '0);
    drain();

    // fully open box, limit above capacity
    tx_idle = 52;
    rx_idle = 27;
    set_box(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 7'd127);
    repeat (50) send_cmd(random_cmd(0), 0, '0);
    drain();
    repeat (50) send_cmd(random_cmd(0), 0, '0);
    drain();

    // no idling, moderate box, full limit; big ticks at the end saturate the clock
    tx_idle = 0;
    rx_idle = 0;
    set_box(32'hF0000000, 32'hE0000000, 32'h10000000, 32'h20000000, 7'd64);
    repeat (80) send_cmd(random_cmd(0), 0, '0);
    repeat (10) send_cmd(random_cmd(1), 0, '0);
    send_cmd(make_cmd(CMD_TICK, 32'hFFFFFFFF), 0, '0);
    repeat (8) send_cmd(random_cmd(1), 0, '0);
    send_cmd(make_cmd(CMD_DRAW, 0), 0, '0);
    drain();

    $display("covered %0d commands, %0d drawn particles, %0d output items checked",
             n_sent, n_drawn, n_got);
    $display("box settings: open, tight, inverted, moderate; limits 0, 5, 64, 127");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
